### design/multi_level_priority_queue_top_defines.svh
// assertion macros shared by the multi-level priority queue modules
// depends on: nothing; users need clk and rst_n in scope
`ifndef MULTI_LEVEL_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define MULTI_LEVEL_PRIORITY_QUEUE_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define MLPQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define MLPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/mlpq_pkg.sv
// shared types and constants of the multi-level priority queue
// depends on: nothing
`default_nettype none

package mlpq_pkg;

  // sizing
  localparam int LEVELS = 8;
  localparam int DEPTH  = 16;
  localparam int LVL_W  = $clog2(LEVELS);
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ADDR_W = LVL_W + PTR_W;
  localparam int DATA_W = 32;

  // configuration register widths and indexes
  localparam int LCFG_W = 4;
  localparam int DCFG_W = 5;
  localparam int CFG_W  = 5;
  localparam int CIDX_W = 1;
  localparam logic [CIDX_W-1:0] CFG_LEVELS = 1'b0;
  localparam logic [CIDX_W-1:0] CFG_DEPTH  = 1'b1;

  // front-to-back queue
  localparam int QD      = 4;
  localparam int QPTR_W  = $clog2(QD);
  localparam int QCNT_W  = $clog2(QD + 1);

  // command codes
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_LEVEL  = 3'd1,
    ST_FIFO_LEVEL = 3'd2,
    ST_NO_LEVEL   = 3'd3,
    ST_ZERO       = 3'd4,
    ST_FULL       = 3'd5,
    ST_EMPTY      = 3'd6
  } status_t;

  // one classified operation for the back end
  typedef struct packed {
    logic              wr;
    logic              rd;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
    status_t           status;
    logic [LVL_W-1:0]  served;
  } mlpq_op_t;

endpackage

`default_nettype wire

### design/mlpq_ram.sv
// generic single-port ram with registered read
// depends on: nothing
`default_nettype none

module mlpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

### design/mlpq_front.sv
// front end: config registers, per-level pointers and counts, classification
// depends on: mlpq_pkg
`default_nettype none

module mlpq_front import mlpq_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_we,
  input  wire logic [CIDX_W-1:0]        cfg_index,
  input  wire logic [CFG_W-1:0]         cfg_data,
  input  wire logic                     accept,
  input  wire logic                     cmd,
  input  wire logic                     level_given,
  input  wire logic [LVL_W-1:0]         level,
  input  wire logic signed [DATA_W-1:0] value,
  output mlpq_op_t                      op
);

  logic [LCFG_W-1:0] levels_r;
  logic [DCFG_W-1:0] depth_r;
  logic [PTR_W-1:0]  rp_r  [LEVELS];
  logic [PTR_W-1:0]  wp_r  [LEVELS];
  logic [CNT_W-1:0]  cnt_r [LEVELS];

  logic [LCFG_W-1:0] nlev;
  logic [DCFG_W-1:0] eff_dep;
  logic              fifo;
  logic [LEVELS-1:0] avail;
  logic              found;
  logic [LVL_W-1:0]  first_lvl;
  logic [LVL_W-1:0]  tgt;
  status_t           status;
  logic              do_push;
  logic              do_pop;
  logic [PTR_W-1:0]  wp_adv;
  logic [PTR_W-1:0]  rp_adv;

  function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p,
                                           input logic [DCFG_W-1:0] d);
    logic [DCFG_W-1:0] n;
    n = DCFG_W'(p) + 1'b1;
    adv = (n >= d) ? '0 : n[PTR_W-1:0];
  endfunction

  // clamp register values to their usable range
  always_comb begin
    if (levels_r == '0) begin
      nlev = LCFG_W'(1);
    end else if (levels_r > LCFG_W'(LEVELS)) begin
      nlev = LCFG_W'(LEVELS);
    end else begin
      nlev = levels_r;
    end
    if (depth_r == '0) begin
      eff_dep = DCFG_W'(1);
    end else if (depth_r > DCFG_W'(DEPTH)) begin
      eff_dep = DCFG_W'(DEPTH);
    end else begin
      eff_dep = depth_r;
    end
  end

  assign fifo = (nlev == LCFG_W'(1));

  // lowest non-empty level in use
  always_comb begin
    found     = 1'b0;
    first_lvl = '0;
    for (int i = 0; i < LEVELS; i++) begin
      avail[i] = (cnt_r[i] != '0) && (LCFG_W'(i) < nlev);
    end
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (avail[i]) begin
        found     = 1'b1;
        first_lvl = LVL_W'(i);
      end
    end
  end

  // request checks in priority order
  always_comb begin
    status = ST_OK;
    tgt    = '0;
    if (level_given && (LCFG_W'(level) >= nlev)) begin
      status = ST_BAD_LEVEL;
    end else if ((cmd == CMD_PUSH) && (value == '0)) begin
      status = ST_ZERO;
    end else if (level_given && fifo) begin
      status = ST_FIFO_LEVEL;
    end else if (level_given) begin
      tgt = level;
    end else if (cmd == CMD_PUSH) begin
      if (!fifo) begin
        status = ST_NO_LEVEL;
      end
    end else if (found) begin
      tgt = first_lvl;
    end else begin
      status = ST_EMPTY;
    end

    if (status == ST_OK) begin
      if ((cmd == CMD_PUSH) && (DCFG_W'(cnt_r[tgt]) >= eff_dep)) begin
        status = ST_FULL;
      end else if ((cmd == CMD_POP) && (cnt_r[tgt] == '0)) begin
        status = ST_EMPTY;
      end
    end
  end

  assign do_push = (status == ST_OK) && (cmd == CMD_PUSH);
  assign do_pop  = (status == ST_OK) && (cmd == CMD_POP);
  assign wp_adv  = adv(wp_r[tgt], eff_dep);
  assign rp_adv  = adv(rp_r[tgt], eff_dep);

  // operation handed to the back end
  always_comb begin
    op.wr     = do_push;
    op.rd     = do_pop;
    op.addr   = do_push ? {tgt, wp_r[tgt]} : {tgt, rp_r[tgt]};
    op.wdata  = $unsigned(value);
    op.status = status;
    op.served = (status == ST_OK) ? tgt : '0;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      levels_r <= LCFG_W'(1);
      depth_r  <= DCFG_W'(DEPTH);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LEVELS: levels_r <= cfg_data[LCFG_W-1:0];
        CFG_DEPTH:  depth_r  <= cfg_data[DCFG_W-1:0];
        default:    ;
      endcase
    end
  end

  // per-level ring bookkeeping; any config write flushes every level
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      for (int i = 0; i < LEVELS; i++) begin
        rp_r[i]  <= '0;
        wp_r[i]  <= '0;
        cnt_r[i] <= '0;
      end
    end else if (accept) begin
      if (do_push) begin
        wp_r[tgt]  <= wp_adv;
        cnt_r[tgt] <= cnt_r[tgt] + 1'b1;
      end else if (do_pop) begin
        rp_r[tgt]  <= rp_adv;
        cnt_r[tgt] <= cnt_r[tgt] - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### design/mlpq_queue.sv
// short queue of classified operations between front and back end
// depends on: mlpq_pkg, multi_level_priority_queue_top_defines.svh
`default_nettype none
`include "multi_level_priority_queue_top_defines.svh"

module mlpq_queue import mlpq_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     wr,
  input  wire mlpq_op_t wr_op,
  input  wire logic     rd,
  output mlpq_op_t      rd_op,
  output logic          full,
  output logic          nempty
);

  mlpq_op_t            ent_r [QD];
  logic [QPTR_W-1:0]   head_r;
  logic [QPTR_W-1:0]   tail_r;
  logic [QCNT_W-1:0]   count_r;
  logic [QCNT_W-1:0]   count_nxt;

  assign full   = (count_r == QCNT_W'(QD));
  assign nempty = (count_r != '0);
  assign rd_op  = ent_r[head_r];

  // occupancy
  always_comb begin
    count_nxt = count_r;
    if (wr && !rd) begin
      count_nxt = count_r + 1'b1;
    end else if (rd && !wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
      if (wr) begin
        tail_r <= (tail_r == QPTR_W'(QD - 1)) ? '0 : tail_r + 1'b1;
      end
      if (rd) begin
        head_r <= (head_r == QPTR_W'(QD - 1)) ? '0 : head_r + 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (wr) begin
      ent_r[tail_r] <= wr_op;
    end
  end

  `MLPQ_ASSERT_IMPL(a_q_no_overflow, wr, !full || rd, "queue written while full")
  `MLPQ_ASSERT_IMPL(a_q_no_underflow, rd, nempty, "queue read while empty")
  `MLPQ_ASSERT_IMPL(a_q_count_range, 1'b1, count_r <= QCNT_W'(QD), "queue count out of range")

endmodule

`default_nettype wire

### design/mlpq_back.sv
// back end: slot store access, read-data stage and output register
// depends on: mlpq_pkg, mlpq_ram, multi_level_priority_queue_top_defines.svh
`default_nettype none
`include "multi_level_priority_queue_top_defines.svh"

module mlpq_back import mlpq_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     q_nempty,
  input  wire mlpq_op_t                 q_op,
  output logic                          q_rd,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [DATA_W-1:0]      out_data,
  output logic [2:0]                    out_status,
  output logic [LVL_W-1:0]              out_level_served
);

  logic              m_valid_r;
  logic              m_valid_nxt;
  logic              m_rd_r;
  status_t           m_status_r;
  logic [LVL_W-1:0]  m_served_r;
  logic              m_move;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_data_r;
  status_t           out_status_r;
  logic [LVL_W-1:0]  out_served_r;
  logic [DATA_W-1:0] ram_rdata;

  // stage hand-off
  assign m_move = m_valid_r && (!out_valid_r || !out_stall);
  assign q_rd   = q_nempty && (!m_valid_r || m_move);

  always_comb begin
    m_valid_nxt = m_valid_r;
    if (q_rd) begin
      m_valid_nxt = 1'b1;
    end else if (m_move) begin
      m_valid_nxt = 1'b0;
    end
  end

  // slot store
  mlpq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (LEVELS * DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (q_rd && q_op.wr),
    .re    (q_rd && q_op.rd),
    .addr  (q_op.addr),
    .wdata (q_op.wdata),
    .rdata (ram_rdata)
  );

  // stage waiting on the store read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
    end else begin
      m_valid_r <= m_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      m_rd_r     <= q_op.rd;
      m_status_r <= q_op.status;
      m_served_r <= q_op.served;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (m_move) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (m_move) begin
      out_data_r   <= m_rd_r ? ram_rdata : '0;
      out_status_r <= m_status_r;
      out_served_r <= m_served_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_data         = $signed(out_data_r);
  assign out_status       = out_status_r;
  assign out_level_served = out_served_r;

  `MLPQ_ASSERT_NEXT(a_rdata_held, m_valid_r && m_rd_r && !m_move, m_valid_r && $stable(ram_rdata), "store read data lost while stalled")
  `MLPQ_ASSERT_IMPL(a_refused_clean, out_valid_r && (out_status_r != ST_OK), (out_data_r == '0) && (out_served_r == '0), "refused result carries data or level")
  `MLPQ_ASSERT_NEXT(a_issue_lands, q_rd, m_valid_r, "issued operation not in read stage")

endmodule

`default_nettype wire

### design/multi_level_priority_queue_top.sv
// path: an accepted word passes the queue, the read-data stage and the output register
// throughput: one word per cycle unless out_stall holds; the front classifies one request
//   per cycle and the back makes one slot store access per cycle through a 4-entry queue
// reset: synchronous active-low clears config to 1 level / 16 slots and empties every
//   level; the slot store itself is not cleared
`default_nettype none

module multi_level_priority_queue_top import mlpq_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_we,
  input  wire logic [CIDX_W-1:0]        cfg_index,
  input  wire logic [CFG_W-1:0]         cfg_data,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic                     in_cmd,
  input  wire logic                     in_level_given,
  input  wire logic [LVL_W-1:0]         in_level,
  input  wire logic signed [DATA_W-1:0] in_value,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [DATA_W-1:0]      out_data,
  output logic [2:0]                    out_status,
  output logic [LVL_W-1:0]              out_level_served
);

  mlpq_op_t front_op;
  mlpq_op_t q_op;
  logic     q_full;
  logic     q_nempty;
  logic     q_rd;
  logic     accept;

  // input word accepted while the queue has room
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // request classification and level bookkeeping
  mlpq_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .accept      (accept),
    .cmd         (in_cmd),
    .level_given (in_level_given),
    .level       (in_level),
    .value       (in_value),
    .op          (front_op)
  );

  // decoupling queue
  mlpq_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (accept),
    .wr_op  (front_op),
    .rd     (q_rd),
    .rd_op  (q_op),
    .full   (q_full),
    .nempty (q_nempty)
  );

  // store access and result delivery
  mlpq_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_nempty         (q_nempty),
    .q_op             (q_op),
    .q_rd             (q_rd),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_data         (out_data),
    .out_status       (out_status),
    .out_level_served (out_level_served)
  );

endmodule

`default_nettype wire
